// ----- src/rbsh_pkg.sv -----
// shared widths and types for the ray box slab hit test
`default_nettype none
package rbsh_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned SizeW  = 31;
  localparam int unsigned NumW   = CoordW + 2;
  localparam int unsigned DenW   = CoordW;
  localparam int unsigned HalfW  = DenW / 2;
  localparam int unsigned PartW  = NumW + HalfW + 1;
  localparam int unsigned ProdW  = NumW + DenW + 1;
  localparam int unsigned InDataW  = 256;
  localparam int unsigned OutDataW = 8;

  typedef struct packed {
    logic                   active;
    logic signed [NumW-1:0] t_in;
    logic signed [NumW-1:0] t_out;
    logic        [DenW-1:0] den;
  } slab_t;

endpackage
`default_nettype wire

// ----- src/ray_box_slab_hit_test_top.sv -----
// 2d ray versus axis-aligned box hit test by the slab method, five-stage pipeline
//
// channel  dir  fields
// s_axis   in   tdata: origin_x, origin_y, dir_x, dir_y, box_left, box_top,
//                      box_width, box_height
// m_axis   out  tdata: hit
//
// one test enters per cycle unless m_axis_tready stalls the pipeline
// the stages are edge offsets, slab ordering, split partial products,
// product sums and the final cross compare, one register stage each
// every stage has its own valid bit and fills when empty or when the stage ahead moves on
// rst_ni clears the valid bits only; data registers carry no reset
`default_nettype none
module ray_box_slab_hit_test_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output      logic                              s_axis_tready,
  // origin_x, origin_y, dir_x, dir_y, box_left, box_top, box_width, box_height
  input  wire logic [rbsh_pkg::InDataW-1:0]      s_axis_tdata,
  output      logic                              m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // hit
  output      logic [rbsh_pkg::OutDataW-1:0]     m_axis_tdata
);

  logic signed [rbsh_pkg::CoordW-1:0] org_x, org_y, dir_x, dir_y, box_left, box_top;
  logic [rbsh_pkg::SizeW-1:0] box_width, box_height;

  assign org_x      = s_axis_tdata[rbsh_pkg::CoordW-1:0];
  assign org_y      = s_axis_tdata[2*rbsh_pkg::CoordW-1:rbsh_pkg::CoordW];
  assign dir_x      = s_axis_tdata[3*rbsh_pkg::CoordW-1:2*rbsh_pkg::CoordW];
  assign dir_y      = s_axis_tdata[4*rbsh_pkg::CoordW-1:3*rbsh_pkg::CoordW];
  assign box_left   = s_axis_tdata[5*rbsh_pkg::CoordW-1:4*rbsh_pkg::CoordW];
  assign box_top    = s_axis_tdata[6*rbsh_pkg::CoordW-1:5*rbsh_pkg::CoordW];
  assign box_width  = s_axis_tdata[6*rbsh_pkg::CoordW+rbsh_pkg::SizeW-1:
                                   6*rbsh_pkg::CoordW];
  assign box_height = s_axis_tdata[6*rbsh_pkg::CoordW+2*rbsh_pkg::SizeW-1:
                                   6*rbsh_pkg::CoordW+rbsh_pkg::SizeW];

  // stage enables
  logic en1, en2, en3, en4, en5;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  assign en5 = !v5_q || m_axis_tready;
  assign en4 = !v4_q || en5;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (en5) v5_q <= v4_q;
    end
  end

  // stage 1: edge offsets from the origin
  logic signed [rbsh_pkg::NumW-1:0] ax_q, ax_d, bx_q, bx_d, ay_q, ay_d, by_q, by_d;
  logic signed [rbsh_pkg::CoordW-1:0] dx1_q, dy1_q;

  always_comb begin
    ax_d = rbsh_pkg::NumW'(box_left) - rbsh_pkg::NumW'(org_x);
    bx_d = rbsh_pkg::NumW'(box_left) + $signed({3'b000, box_width})
         - rbsh_pkg::NumW'(org_x);
    ay_d = rbsh_pkg::NumW'(box_top) - rbsh_pkg::NumW'(org_y);
    by_d = rbsh_pkg::NumW'(box_top) + $signed({3'b000, box_height})
         - rbsh_pkg::NumW'(org_y);
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      ax_q  <= ax_d;
      bx_q  <= bx_d;
      ay_q  <= ay_d;
      by_q  <= by_d;
      dx1_q <= dir_x;
      dy1_q <= dir_y;
    end
  end

  // stage 2: ordered slab numerators, non-negative denominators and slab checks
  rbsh_pkg::slab_t sx_d, sy_d, sx_q, sy_q;
  logic pre_d, pre2_q, pre3_q, pre4_q;
  logic both2_q, both3_q, both4_q;

  function automatic rbsh_pkg::slab_t mk_slab(logic signed [rbsh_pkg::NumW-1:0] a,
                                               logic signed [rbsh_pkg::NumW-1:0] b,
                                               logic signed [rbsh_pkg::CoordW-1:0] d);
    rbsh_pkg::slab_t s;
    s.active = (d != '0);
    if (!d[rbsh_pkg::CoordW-1]) begin
      s.t_in  = a;
      s.t_out = b;
      s.den   = rbsh_pkg::DenW'(d);
    end else begin
      s.t_in  = -b;
      s.t_out = -a;
      s.den   = rbsh_pkg::DenW'(-d);
    end
    return s;
  endfunction

  function automatic logic slab_ok(logic signed [rbsh_pkg::NumW-1:0] a,
                                   logic signed [rbsh_pkg::NumW-1:0] b,
                                   logic signed [rbsh_pkg::CoordW-1:0] d);
    logic ok;
    if (d == '0) begin
      ok = (a <= 0) && (b >= 0);
    end else if (!d[rbsh_pkg::CoordW-1]) begin
      ok = (b >= 0);
    end else begin
      ok = (a <= 0);
    end
    return ok;
  endfunction

  always_comb begin
    sx_d  = mk_slab(ax_q, bx_q, dx1_q);
    sy_d  = mk_slab(ay_q, by_q, dy1_q);
    pre_d = slab_ok(ax_q, bx_q, dx1_q) && slab_ok(ay_q, by_q, dy1_q);
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      sx_q    <= sx_d;
      sy_q    <= sy_d;
      pre2_q  <= pre_d;
      both2_q <= sx_d.active && sy_d.active;
    end
    if (en3) begin
      pre3_q  <= pre2_q;
      both3_q <= both2_q;
    end
    if (en4) begin
      pre4_q  <= pre3_q;
      both4_q <= both3_q;
    end
  end

  // stages 3 and 4: cross products
  logic signed [rbsh_pkg::ProdW-1:0] in_x_den_y, out_y_den_x, in_y_den_x, out_x_den_y;

  rbsh_mul u_mul_inx (
    .clk_i     (clk_i),
    .part_en_i (en3),
    .sum_en_i  (en4),
    .num_i     (sx_q.t_in),
    .den_i     (sy_q.den),
    .prod_o    (in_x_den_y)
  );

  rbsh_mul u_mul_outy (
    .clk_i     (clk_i),
    .part_en_i (en3),
    .sum_en_i  (en4),
    .num_i     (sy_q.t_out),
    .den_i     (sx_q.den),
    .prod_o    (out_y_den_x)
  );

  rbsh_mul u_mul_iny (
    .clk_i     (clk_i),
    .part_en_i (en3),
    .sum_en_i  (en4),
    .num_i     (sy_q.t_in),
    .den_i     (sx_q.den),
    .prod_o    (in_y_den_x)
  );

  rbsh_mul u_mul_outx (
    .clk_i     (clk_i),
    .part_en_i (en3),
    .sum_en_i  (en4),
    .num_i     (sx_q.t_out),
    .den_i     (sy_q.den),
    .prod_o    (out_x_den_y)
  );

  // stage 5: compare and output register
  logic hit_q, hit_d;

  always_comb begin
    hit_d = pre4_q && (!both4_q || ((in_x_den_y <= out_y_den_x) &&
                                    (in_y_den_x <= out_x_den_y)));
  end

  always_ff @(posedge clk_i) begin
    if (en5) begin
      hit_q <= hit_d;
    end
  end

  assign m_axis_tvalid = v5_q;
  assign m_axis_tdata  = {{(rbsh_pkg::OutDataW-1){1'b0}}, hit_q};

`ifndef ASSERT_OFF
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v1_q)
    else $error("accepted transfer did not reach stage 1");

  a_empty_s1_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> s_axis_tready)
    else $error("input stalled with empty first stage");

  a_no_pre_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en5 && v4_q && !pre4_q |=> m_axis_tvalid && !m_axis_tdata[0])
    else $error("hit reported for a ray rejected by a slab check");

  a_stage_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && en4 |=> v4_q)
    else $error("item lost between product stages");

  a_zero_dir_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q && en2 && (dx1_q == '0) && (ax_q > 0) |=> !pre2_q)
    else $error("origin outside a zero-direction slab not rejected");
`endif

endmodule
`default_nettype wire

// ----- src/rbsh_mul.sv -----
// two-stage signed numerator by unsigned denominator multiplier
`default_nettype none
module rbsh_mul (
  input  wire logic                               clk_i,
  input  wire logic                               part_en_i,
  input  wire logic                               sum_en_i,
  input  wire logic signed [rbsh_pkg::NumW-1:0]   num_i,
  input  wire logic        [rbsh_pkg::DenW-1:0]   den_i,
  output      logic signed [rbsh_pkg::ProdW-1:0]  prod_o
);

  logic signed [rbsh_pkg::PartW-1:0] part_lo_q, part_lo_d;
  logic signed [rbsh_pkg::PartW-1:0] part_hi_q, part_hi_d;
  logic signed [rbsh_pkg::ProdW-1:0] prod_q, prod_d;

  always_comb begin
    part_lo_d = rbsh_pkg::PartW'(num_i)
              * rbsh_pkg::PartW'($signed({1'b0, den_i[rbsh_pkg::HalfW-1:0]}));
    part_hi_d = rbsh_pkg::PartW'(num_i)
              * rbsh_pkg::PartW'($signed({1'b0, den_i[rbsh_pkg::DenW-1:rbsh_pkg::HalfW]}));
    prod_d    = (rbsh_pkg::ProdW'(part_hi_q) <<< rbsh_pkg::HalfW)
              + rbsh_pkg::ProdW'(part_lo_q);
  end

  always_ff @(posedge clk_i) begin
    if (part_en_i) begin
      part_lo_q <= part_lo_d;
      part_hi_q <= part_hi_d;
    end
    if (sum_en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

// ----- dv/ray_box_slab_hit_test_top_test.sv -----
// self-checking testbench for the 2d ray versus box slab hit test
module ray_box_slab_hit_test_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          One   = 65536;
  localparam int          Half  = 32768;
  localparam int          MinS  = 32'sh8000_0000;
  localparam int          MaxS  = 32'sh7FFF_FFFF;
  localparam int unsigned MaxSz = 32'h7FFF_FFFF;
  localparam int          RandN = 1050;

  // one test as packed on s_axis_tdata, origin_x in the lowest bits
  typedef struct packed {
    logic        [30:0] box_height;
    logic        [30:0] box_width;
    logic signed [31:0] box_top;
    logic signed [31:0] box_left;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_x;
  } ray_box_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [rbsh_pkg::InDataW-1:0]     s_axis_tdata = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [rbsh_pkg::OutDataW-1:0]    m_axis_tdata;

  ray_box_t ray_tests_q[$];
  bit       hit_expect_q[$];
  bit       in_taken = 1'b0;
  int       sent_n = 0;
  int       total_n = 0;
  int       drain_a = 0;
  int       drain_b = 0;
  int       src_gap = 0;
  int       sink_gap = 0;
  int       errors_n = 0;
  int       checked_n = 0;
  int       hits_n = 0;

  ray_box_slab_hit_test_top uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // entry of one slab <= exit of the other, exact by cross-multiplication
  function automatic bit entry_le_exit(longint in_n, longint in_d, longint out_n,
                                       longint out_d);
    logic signed [127:0] lhs;
    logic signed [127:0] rhs;
    lhs = 128'(in_n);
    rhs = 128'(out_n);
    lhs = lhs * 128'(out_d);
    rhs = rhs * 128'(in_d);
    return lhs <= rhs;
  endfunction

  function automatic bit predict_hit(ray_box_t r);
    longint org[2], dir[2], lo[2], sz[2];
    longint t_in[2], t_out[2], den[2];
    longint hi;
    bit     live[2];
    bit     hit;
    org[0] = longint'(r.origin_x);
    org[1] = longint'(r.origin_y);
    dir[0] = longint'(r.dir_x);
    dir[1] = longint'(r.dir_y);
    lo[0]  = longint'(r.box_left);
    lo[1]  = longint'(r.box_top);
    sz[0]  = longint'(r.box_width);
    sz[1]  = longint'(r.box_height);
    hit = 1'b1;
    for (int i = 0; i < 2; i++) begin
      hi = lo[i] + sz[i];
      live[i] = (dir[i] != 0);
      t_in[i] = 0;
      t_out[i] = 0;
      den[i] = 1;
      if (dir[i] == 0) begin
        if (org[i] < lo[i] || org[i] > hi) hit = 1'b0;
      end else if (dir[i] > 0) begin
        t_in[i] = lo[i] - org[i];
        t_out[i] = hi - org[i];
        den[i] = dir[i];
      end else begin
        t_in[i] = org[i] - hi;
        t_out[i] = org[i] - lo[i];
        den[i] = -dir[i];
      end
    end
    if (hit) begin
      if ((live[0] && t_out[0] < 0) || (live[1] && t_out[1] < 0)) hit = 1'b0;
      if (live[0] && live[1] &&
          (!entry_le_exit(t_in[0], den[0], t_out[1], den[1]) ||
           !entry_le_exit(t_in[1], den[1], t_out[0], den[0]))) hit = 1'b0;
    end
    return hit;
  endfunction

  function automatic ray_box_t mk_ray(int ox, int oy, int dx, int dy, int bl, int bt,
                                      int unsigned bw, int unsigned bh);
    ray_box_t r;
    r.origin_x   = ox;
    r.origin_y   = oy;
    r.dir_x      = dx;
    r.dir_y      = dy;
    r.box_left   = bl;
    r.box_top    = bt;
    r.box_width  = bw[30:0];
    r.box_height = bh[30:0];
    return r;
  endfunction

  function automatic int random_dir();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return MinS;
      default: return $signed($urandom) >>> $urandom_range(0, 30);
    endcase
  endfunction

  function automatic ray_box_t random_ray();
    ray_box_t r;
    int       sh, k, px, py;
    case ($urandom_range(0, 9))
      0: begin
        r = mk_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom_range(0, MaxSz), $urandom_range(0, MaxSz));
      end
      1: begin
        // ray whose line runs exactly through a corner of the box
        sh = $urandom_range(12, 20);
        r.box_left   = $signed($urandom) >>> sh;
        r.box_top    = $signed($urandom) >>> sh;
        r.box_width  = 31'($urandom_range(0, 32'd1 << (31 - sh)));
        r.box_height = 31'($urandom_range(0, 32'd1 << (31 - sh)));
        r.dir_x = ($urandom_range(0, 3) == 0) ? 0 : ($signed($urandom) >>> (sh + 4));
        r.dir_y = ($urandom_range(0, 3) == 0) ? 0 : ($signed($urandom) >>> (sh + 4));
        px = r.box_left + ($urandom_range(0, 1) ? int'(r.box_width) : 0);
        py = r.box_top + ($urandom_range(0, 1) ? int'(r.box_height) : 0);
        k = $urandom_range(0, 8) - 3;
        r.origin_x = px - k * r.dir_x;
        r.origin_y = py - k * r.dir_y;
      end
      default: begin
        sh = $urandom_range(0, 28);
        r.origin_x   = $signed($urandom) >>> sh;
        r.origin_y   = $signed($urandom) >>> sh;
        r.box_left   = $signed($urandom) >>> sh;
        r.box_top    = $signed($urandom) >>> sh;
        r.dir_x      = random_dir();
        r.dir_y      = random_dir();
        r.box_width  = ($urandom_range(0, 9) == 0) ? '0 : 31'($urandom >> (sh + 1));
        r.box_height = ($urandom_range(0, 9) == 0) ? '0 : 31'($urandom >> (sh + 1));
      end
    endcase
    return r;
  endfunction

  function bit idle_ok();
    return (sent_n < total_n - 150) && ((sent_n / 90) % 3 != 2);
  endfunction

  // source side
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (idle_ok() && $urandom_range(0, 5) == 0) begin
        src_gap = $urandom_range(0, 16);
        s_axis_tvalid <= 1'b0;
      end else if ((sent_n == drain_a || sent_n == drain_b) && hit_expect_q.size() != 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (ray_tests_q.size() != 0) begin
        s_axis_tdata  <= {2'b00, ray_tests_q.pop_front()};
        s_axis_tvalid <= 1'b1;
        sent_n++;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // sink side
  always @(negedge clk_i) begin
    if (sink_gap > 0) begin
      sink_gap--;
      m_axis_tready <= 1'b0;
    end else if (idle_ok() && $urandom_range(0, 5) == 0) begin
      sink_gap = $urandom_range(0, 16);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : monitor
    ray_box_t rb;
    bit       want;
    in_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (hit_expect_q.size() == 0) begin
        errors_n++;
        $display("%0t: result transfer with none expected, actual hit=%b", $realtime,
                 m_axis_tdata[0]);
      end else begin
        want = hit_expect_q.pop_front();
        checked_n++;
        if (want) hits_n++;
        if (m_axis_tdata[0] !== want) begin
          errors_n++;
          $display("%0t: hit mismatch, expected %b actual %b", $realtime, want,
                   m_axis_tdata[0]);
        end
      end
    end
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      rb = s_axis_tdata[253:0];
      hit_expect_q.push_back(predict_hit(rb));
    end
  end

  initial begin
    ray_tests_q.push_back(mk_ray(-10 * One, Half, One, 0, 0, 0, One, One));
    ray_tests_q.push_back(mk_ray(-10 * One, Half, -One, 0, 0, 0, One, One));
    ray_tests_q.push_back(mk_ray(Half, Half, 0, 0, 0, 0, One, One));
    ray_tests_q.push_back(mk_ray(2 * One, Half, 0, 0, 0, 0, One, One));
    ray_tests_q.push_back(mk_ray(One, One, 0, 0, 0, 0, One, One));
    ray_tests_q.push_back(mk_ray(-2 * One, -2 * One, One, One, 0, 0, 0, 0));
    ray_tests_q.push_back(mk_ray(-2 * One, -One, One, One, 0, 0, 0, 0));
    ray_tests_q.push_back(mk_ray(One, Half, One, 0, 0, 0, One, One));
    ray_tests_q.push_back(mk_ray(0, 2 * One, One, -One, 0, 0, One, One));
    ray_tests_q.push_back(mk_ray(0, 2 * One + 1, One, -One, 0, 0, One, One));
    ray_tests_q.push_back(mk_ray(Half, -5 * One, 0, One, 0, 0, One, One));
    ray_tests_q.push_back(mk_ray(Half, 5 * One, 0, One, 0, 0, One, One));
    ray_tests_q.push_back(mk_ray(Half, -5 * One, 0, -One, 0, 0, One, One));
    ray_tests_q.push_back(mk_ray(-3 * One, Half, 3 * One, One, 0, 0, One, One));
    ray_tests_q.push_back(mk_ray(MaxS, 0, MinS, 0, MinS, MinS, MaxSz, MaxSz));
    ray_tests_q.push_back(mk_ray(MinS, MinS, MaxS, MaxS, MaxS, MaxS, MaxSz, MaxSz));
    ray_tests_q.push_back(mk_ray(MaxS, MaxS, MinS, MinS, MinS, MinS, 0, 0));
    ray_tests_q.push_back(mk_ray(0, 0, MinS, One, -One, -One, 2 * One, 2 * One));
    ray_tests_q.push_back(mk_ray(0, 0, 0, 0, 0, 0, 0, 0));
    ray_tests_q.push_back(mk_ray(-1, -1, -1, -1, -1, -1, MaxSz, MaxSz));
    drain_a = ray_tests_q.size();
    for (int i = 0; i < RandN; i++) ray_tests_q.push_back(random_ray());
    total_n = ray_tests_q.size();
    drain_b = total_n / 2;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (ray_tests_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (hit_expect_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("%0d ray tests checked (%0d hits, %0d misses): extremes, touching, zero",
             checked_n, hits_n, checked_n - hits_n);
    $display("direction and degenerate boxes, under random stalls on both sides");
    if (errors_n == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", hit_expect_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
